[hdl/rocl_pkg.sv]
// ----------------------------------------------------------------------------
// Rectangle overlay cell lookup - shared definitions
// Entry layout of the rectangle table, request codes and the blank glyph.
// ----------------------------------------------------------------------------
`default_nettype none

package rocl_pkg;

   localparam int unsigned COL_W   = 7;
   localparam int unsigned ROW_W   = 5;
   localparam int unsigned GLYPH_W = 8;
   localparam int unsigned ENTRY_W = 32;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 8'd32;

   // One stored rectangle, corners inclusive
   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic [ROW_W-1:0]   bottom;
      logic [COL_W-1:0]   right;
      logic [ROW_W-1:0]   top;
      logic [COL_W-1:0]   left;
   } rect_entry_type;

endpackage

`default_nettype wire

[hdl/rectangle_overlay_cell_lookup.sv]
// Add and clear accept a new beat every cycle.
// A query walks one stored rectangle per cycle (newest first, one read of the
// rectangle RAM per cycle, stopping at the first cover). The answer is held
// in the finishing state until the output register is free, and the next beat
// is taken once the answer has been written there; the input stalls till then.
// Reset empties the table at once (count cleared); no clearing pass.
// ----------------------------------------------------------------------------
// Rectangle overlay cell lookup - top level
// Stores rectangles in a RAM and answers per-cell queries by walking the
// table from the newest entry down.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_overlay_cell_lookup #(
   parameter int unsigned MAX_RECTS = 128
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_func,
   input  wire logic [rocl_pkg::COL_W-1:0]           req_left,
   input  wire logic [rocl_pkg::ROW_W-1:0]           req_top,
   input  wire logic [rocl_pkg::COL_W-1:0]           req_right,
   input  wire logic [rocl_pkg::ROW_W-1:0]           req_bottom,
   input  wire logic [rocl_pkg::GLYPH_W-1:0]         req_glyph,
   input  wire logic [rocl_pkg::ROW_W-1:0]           req_query_row,
   input  wire logic [rocl_pkg::COL_W-1:0]           req_query_col,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [rocl_pkg::GLYPH_W-1:0]         rsp_cell_glyph,
   output logic                                      rsp_covered
);

   localparam int unsigned AW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_RECTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [rocl_pkg::ROW_W-1:0]       q_row_ff, q_row_in;
   logic [rocl_pkg::COL_W-1:0]       q_col_ff, q_col_in;
   logic [rocl_pkg::GLYPH_W-1:0]     pend_glyph_ff, pend_glyph_in;
   logic                             pend_hit_ff, pend_hit_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rocl_pkg::GLYPH_W-1:0]     rsp_glyph_ff, rsp_glyph_in;
   logic                             rsp_covered_ff, rsp_covered_in;

   logic                             req_take;
   logic                             not_full;
   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [AW-1:0]                    rd_addr;
   logic [CNT_W-1:0]                 count_dec;
   logic [rocl_pkg::ENTRY_W-1:0]     rd_data;
   rocl_pkg::rect_entry_type         wr_entry;
   rocl_pkg::rect_entry_type         rd_entry;
   logic                             entry_hit;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign not_full  = (count_ff < CNT_W'(MAX_RECTS));
   assign count_dec = count_ff - CNT_W'(1);

   assign wr_entry.left   = req_left;
   assign wr_entry.top    = req_top;
   assign wr_entry.right  = req_right;
   assign wr_entry.bottom = req_bottom;
   assign wr_entry.glyph  = req_glyph;

   assign wr_en   = req_take && (req_func == rocl_pkg::FUNC_ADD) && not_full;
   assign wr_addr = count_ff[AW-1:0];

   // Read the newest entry at accept, then step down one entry a cycle
   assign rd_addr  = (state_ff == ST_SCAN) ? (idx_ff - AW'(1)) : count_dec[AW-1:0];
   assign rd_entry = rd_data;

   rocl_ram #(
      .WIDTH (rocl_pkg::ENTRY_W),
      .DEPTH (MAX_RECTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rocl_match u_match (
      .entry (rd_entry),
      .row   (q_row_ff),
      .col   (q_col_ff),
      .hit   (entry_hit)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      q_row_in       = q_row_ff;
      q_col_in       = q_col_ff;
      pend_glyph_in  = pend_glyph_ff;
      pend_hit_in    = pend_hit_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_glyph_in   = rsp_glyph_ff;
      rsp_covered_in = rsp_covered_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_func)
                  rocl_pkg::FUNC_ADD: begin
                     if (not_full) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  rocl_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  rocl_pkg::FUNC_QUERY: begin
                     q_row_in = req_query_row;
                     q_col_in = req_query_col;
                     idx_in   = count_dec[AW-1:0];
                     if (count_ff == '0) begin
                        pend_glyph_in = rocl_pkg::SPACE_GLYPH;
                        pend_hit_in   = 1'b0;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (entry_hit) begin
               pend_glyph_in = rd_entry.glyph;
               pend_hit_in   = 1'b1;
               state_in      = ST_DONE;
            end else if (idx_ff == '0) begin
               pend_glyph_in = rocl_pkg::SPACE_GLYPH;
               pend_hit_in   = 1'b0;
               state_in      = ST_DONE;
            end else begin
               idx_in = idx_ff - AW'(1);
            end
         end
         ST_DONE: begin
            // Hold the answer until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_glyph_in   = pend_glyph_ff;
               rsp_covered_in = pend_hit_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      q_row_ff       <= q_row_in;
      q_col_ff       <= q_col_in;
      pend_glyph_ff  <= pend_glyph_in;
      pend_hit_ff    <= pend_hit_in;
      rsp_glyph_ff   <= rsp_glyph_in;
      rsp_covered_ff <= rsp_covered_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_glyph = rsp_glyph_ff;
   assign rsp_covered    = rsp_covered_ff;

   // Table never holds more rectangles than it has room for
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS))
      else $error("rectangle count beyond table depth");

   // The walk stays inside the filled part of the table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("scan index outside filled entries");

   // A new response only comes out of the finishing state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside finish");

   // An accepted add into a table with room grows it by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_func == rocl_pkg::FUNC_ADD) && not_full)
         |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("add did not advance rectangle count");

endmodule

`default_nettype wire

[hdl/rocl_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rocl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/rocl_match.sv]
// ----------------------------------------------------------------------------
// Rectangle cover test
// Tells whether one stored rectangle covers the queried cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rocl_match (
   input  wire rocl_pkg::rect_entry_type           entry,
   input  wire logic [rocl_pkg::ROW_W-1:0]         row,
   input  wire logic [rocl_pkg::COL_W-1:0]         col,
   output logic                                    hit
);

   // An inverted rectangle fails one of the bounds and covers nothing
   assign hit = (entry.left <= col) && (col <= entry.right) &&
                (entry.top <= row) && (row <= entry.bottom);

endmodule

`default_nettype wire

[tb/rocl_cell_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle overlay cell lookup - channel checker
// Watches the request and response channels, keeps its own rectangle table,
// predicts the answer of every accepted lookup and compares each response
// beat with the oldest outstanding answer.
// ----------------------------------------------------------------------------

module rocl_cell_checker #(
   parameter int unsigned MAX_RECTS = 128
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [1:0]                    req_func,
   input  wire logic [rocl_pkg::COL_W-1:0]    req_left,
   input  wire logic [rocl_pkg::ROW_W-1:0]    req_top,
   input  wire logic [rocl_pkg::COL_W-1:0]    req_right,
   input  wire logic [rocl_pkg::ROW_W-1:0]    req_bottom,
   input  wire logic [rocl_pkg::GLYPH_W-1:0]  req_glyph,
   input  wire logic [rocl_pkg::ROW_W-1:0]    req_query_row,
   input  wire logic [rocl_pkg::COL_W-1:0]    req_query_col,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [rocl_pkg::GLYPH_W-1:0]  rsp_cell_glyph,
   input  wire logic                          rsp_covered,
   output int unsigned                        fail_count,
   output int unsigned                        pending,
   output int unsigned                        lookups_checked,
   output int unsigned                        covered_seen
);

   typedef struct {
      logic [rocl_pkg::GLYPH_W-1:0] glyph;
      logic                         covered;
   } cell_answer_type;

   rocl_pkg::rect_entry_type  rect_store [MAX_RECTS];
   int unsigned               rect_total;
   cell_answer_type           expected_cells [$];
   cell_answer_type           oldest;
   rocl_pkg::rect_entry_type  new_rect;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Walk newest to oldest; the first rectangle that covers the cell wins
   function automatic cell_answer_type lookup_cell(
      input logic [rocl_pkg::ROW_W-1:0] row,
      input logic [rocl_pkg::COL_W-1:0] col);
      cell_answer_type ans;
      ans.glyph   = rocl_pkg::SPACE_GLYPH;
      ans.covered = 1'b0;
      for (int i = int'(rect_total) - 1; i >= 0 && !ans.covered; i--) begin
         if (rect_store[i].left <= col && col <= rect_store[i].right &&
             rect_store[i].top <= row && row <= rect_store[i].bottom) begin
            ans.glyph   = rect_store[i].glyph;
            ans.covered = 1'b1;
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rect_total = 0;
         expected_cells.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               report_mismatch($sformatf("response beat with no lookup outstanding (glyph %0d)",
                                         rsp_cell_glyph));
            end else begin
               oldest = expected_cells.pop_front();
               lookups_checked++;
               if (oldest.covered)
                  covered_seen++;
               if (rsp_cell_glyph !== oldest.glyph)
                  report_mismatch($sformatf("cell_glyph got %0d want %0d",
                                            rsp_cell_glyph, oldest.glyph));
               if (rsp_covered !== oldest.covered)
                  report_mismatch($sformatf("covered got %0b want %0b",
                                            rsp_covered, oldest.covered));
            end
         end
         if (req_valid && !req_stall) begin
            case (req_func)
               rocl_pkg::FUNC_ADD: begin
                  // drop the add once the table is full
                  if (rect_total < MAX_RECTS) begin
                     new_rect.left   = req_left;
                     new_rect.top    = req_top;
                     new_rect.right  = req_right;
                     new_rect.bottom = req_bottom;
                     new_rect.glyph  = req_glyph;
                     rect_store[rect_total] = new_rect;
                     rect_total++;
                  end
               end
               rocl_pkg::FUNC_QUERY:
                  expected_cells.push_back(lookup_cell(req_query_row, req_query_col));
               rocl_pkg::FUNC_CLEAR: rect_total = 0;
               default: ;
            endcase
         end
      end
      pending = expected_cells.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle overlay cell lookup - testbench top
// Drives add, lookup and clear beats with random gaps and response stalls,
// fills the table past its limit, and leaves checking to the channel checker.
// ----------------------------------------------------------------------------

module tb;

   localparam int unsigned MAX_RECTS      = 128;
   localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
   localparam int unsigned ITEM_TARGET    = 1750;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned DRAIN_CYCLES   = 150;
   localparam int unsigned WATCHDOG_LIMIT = 3000;

   typedef struct {
      int l;
      int t;
      int r;
      int b;
   } corner_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_func;
   logic [rocl_pkg::COL_W-1:0]    req_left;
   logic [rocl_pkg::ROW_W-1:0]    req_top;
   logic [rocl_pkg::COL_W-1:0]    req_right;
   logic [rocl_pkg::ROW_W-1:0]    req_bottom;
   logic [rocl_pkg::GLYPH_W-1:0]  req_glyph;
   logic [rocl_pkg::ROW_W-1:0]    req_query_row;
   logic [rocl_pkg::COL_W-1:0]    req_query_col;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [rocl_pkg::GLYPH_W-1:0]  rsp_cell_glyph;
   logic                          rsp_covered;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned lookups_checked;
   int unsigned covered_seen;

   bit          no_idle;
   bit          hold_rsp;
   int unsigned items_sent;
   int unsigned fill;
   int unsigned adds_dropped;
   int unsigned idle_cycles;
   corner_type  recent [$];

   rectangle_overlay_cell_lookup #(.MAX_RECTS(MAX_RECTS)) DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_left, .req_top, .req_right,
      .req_bottom, .req_glyph, .req_query_row, .req_query_col,
      .rsp_valid, .rsp_stall, .rsp_cell_glyph, .rsp_covered
   );

   rocl_cell_checker #(.MAX_RECTS(MAX_RECTS)) u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_left, .req_top, .req_right,
      .req_bottom, .req_glyph, .req_query_row, .req_query_col,
      .rsp_valid, .rsp_stall, .rsp_cell_glyph, .rsp_covered,
      .fail_count, .pending, .lookups_checked, .covered_seen
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_beat(input logic [1:0] func,
                            input int l, input int t, input int r, input int b,
                            input int g, input int row, input int col);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      items_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func      <= func;
      req_left      <= l[rocl_pkg::COL_W-1:0];
      req_top       <= t[rocl_pkg::ROW_W-1:0];
      req_right     <= r[rocl_pkg::COL_W-1:0];
      req_bottom    <= b[rocl_pkg::ROW_W-1:0];
      req_glyph     <= g[rocl_pkg::GLYPH_W-1:0];
      req_query_row <= row[rocl_pkg::ROW_W-1:0];
      req_query_col <= col[rocl_pkg::COL_W-1:0];
      req_valid     <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic add_rect(input int l, input int t, input int r, input int b, input int g);
      corner_type c;
      c.l = l; c.t = t; c.r = r; c.b = b;
      recent.push_back(c);
      if (recent.size() > 16)
         void'(recent.pop_front());
      if (fill < MAX_RECTS)
         fill++;
      else
         adds_dropped++;
      send_beat(rocl_pkg::FUNC_ADD, l, t, r, b, g, $urandom_range(0, 31),
                $urandom_range(0, 127));
   endtask

   task automatic ask_cell(input int row, input int col);
      send_beat(rocl_pkg::FUNC_QUERY, $urandom_range(0, 127), $urandom_range(0, 31),
                $urandom_range(0, 127), $urandom_range(0, 31), $urandom_range(0, 255),
                row, col);
   endtask

   task automatic clear_table();
      fill = 0;
      send_beat(rocl_pkg::FUNC_CLEAR, $urandom_range(0, 127), $urandom_range(0, 31),
                $urandom_range(0, 127), $urandom_range(0, 31), $urandom_range(0, 255),
                $urandom_range(0, 31), $urandom_range(0, 127));
   endtask

   // Mostly on-grid rectangles; wild ones span the full field range
   task automatic add_random_rect(input bit wild);
      int l, t, r, b;
      if (wild) begin
         l = $urandom_range(0, 127);
         t = $urandom_range(0, 31);
         r = $urandom_range(0, 127);
         b = $urandom_range(0, 31);
      end else begin
         l = $urandom_range(0, 79);
         r = l + $urandom_range(0, 25);
         if (r > 79) r = 79;
         t = $urandom_range(0, 24);
         b = t + $urandom_range(0, 8);
         if (b > 24) b = 24;
      end
      add_rect(l, t, r, b, $urandom_range(0, 255));
   endtask

   // Aim most lookups at a recent rectangle, inside it or just past its edges
   task automatic ask_random_cell();
      corner_type c;
      int row, col;
      if (recent.size() > 0 && $urandom_range(0, 3) != 0) begin
         c   = recent[$urandom_range(0, recent.size() - 1)];
         row = $urandom_range(0, 2) == 0 ? c.t - 1 + $urandom_range(0, 2) * (c.b - c.t + 2) / 2
                                        : c.t + $urandom_range(0, 31) % (c.b - c.t + 1 > 0 ?
                                                                          c.b - c.t + 1 : 1);
         col = $urandom_range(0, 2) == 0 ? c.l - 1 + $urandom_range(0, 2) * (c.r - c.l + 2) / 2
                                        : c.l + $urandom_range(0, 127) % (c.r - c.l + 1 > 0 ?
                                                                           c.r - c.l + 1 : 1);
         if (row < 0) row = 0;
         if (row > 31) row = 31;
         if (col < 0) col = 0;
         if (col > 127) col = 127;
      end else if ($urandom_range(0, 7) == 0) begin
         row = $urandom_range(0, 31);
         col = $urandom_range(0, 127);
      end else begin
         row = $urandom_range(0, 24);
         col = $urandom_range(0, 79);
      end
      ask_cell(row, col);
   endtask

   task automatic noise_beat();
      logic [1:0] func;
      func = 2'($urandom_range(0, 3));
      case (func)
         rocl_pkg::FUNC_ADD:   add_random_rect(1'b1);
         rocl_pkg::FUNC_QUERY: ask_cell($urandom_range(0, 31), $urandom_range(0, 127));
         rocl_pkg::FUNC_CLEAR: clear_table();
         default:    send_beat(FUNC_UNUSED, $urandom_range(0, 127), $urandom_range(0, 31),
                               $urandom_range(0, 127), $urandom_range(0, 31),
                               $urandom_range(0, 255), $urandom_range(0, 31),
                               $urandom_range(0, 127));
      endcase
   endtask

   // Always lets at least one falling edge pass so valid is dropped cleanly
   task automatic wait_drained();
      do @(negedge clock); while (pending != 0);
   endtask

   // Response side: random stall per beat, one long hold-off on request
   initial begin
      int unsigned w;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            w = no_idle ? 0 : $urandom_range(0, 3);
            if (w > 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   // Watchdog: end the run when no beat moves for too long
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no beat for %0d cycles, %0d lookups outstanding",
               WATCHDOG_LIMIT, pending);
      $display("[rectangle_overlay_cell_lookup] ERROR");
      $finish;
   end

   initial begin
      int unsigned episode, kind, n;
      bit held;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = rocl_pkg::FUNC_ADD;
      req_left      = '0;
      req_top       = '0;
      req_right     = '0;
      req_bottom    = '0;
      req_glyph     = '0;
      req_query_row = '0;
      req_query_col = '0;
      no_idle       = 1'b0;
      hold_rsp      = 1'b0;
      held          = 1'b0;
      items_sent    = 0;
      fill          = 0;
      adds_dropped  = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table, grid corners, extreme fields, inverted corners,
      // glyphs 0 and space, newest-wins overlap, unused code, clear
      ask_cell(0, 0);
      add_rect(0, 0, 79, 24, 35);
      ask_cell(0, 0);
      ask_cell(24, 79);
      ask_cell(31, 127);
      add_rect(127, 31, 127, 31, 255);
      ask_cell(31, 127);
      add_rect(10, 5, 3, 8, 120);
      add_rect(2, 9, 6, 4, 121);
      ask_cell(6, 5);
      add_rect(40, 12, 40, 12, 0);
      ask_cell(12, 40);
      add_rect(50, 10, 60, 20, int'(rocl_pkg::SPACE_GLYPH));
      ask_cell(15, 55);
      add_rect(10, 5, 20, 15, 66);
      ask_cell(5, 10);
      ask_cell(4, 10);
      ask_cell(16, 20);
      ask_cell(15, 21);
      send_beat(FUNC_UNUSED, 127, 31, 127, 31, 255, 31, 127);
      ask_cell(15, 20);
      clear_table();
      ask_cell(12, 40);
      clear_table();
      req_valid <= 1'b0;
      wait_drained();

      episode = 0;
      while (items_sent < ITEM_TARGET) begin
         episode++;
         no_idle = (episode % 7 == 3);
         kind = (episode == 1) ? 1 : $urandom_range(0, 19);
         if (kind == 0) begin
            repeat ($urandom_range(3, 10)) noise_beat();
         end else begin
            if ($urandom_range(0, 2) != 0 || kind == 1)
               clear_table();
            n = (kind == 1) ? MAX_RECTS - fill + $urandom_range(1, 4) : $urandom_range(1, 10);
            repeat (n) add_random_rect($urandom_range(0, 7) == 0);
            // Long response hold-off while lookups keep coming
            if (!held && items_sent > 500) begin
               hold_rsp = 1'b1;
               held     = 1'b1;
            end
            repeat ($urandom_range(4, 14)) ask_random_cell();
         end
         if (episode % 10 == 0) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d beats over %0d episodes; %0d lookups checked, %0d covered",
               items_sent, episode, lookups_checked, covered_seen);
      $display("adds dropped on a full table: %0d, mismatches: %0d",
               adds_dropped, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("[rectangle_overlay_cell_lookup] OK");
      else
         $display("[rectangle_overlay_cell_lookup] ERROR");
      $finish;
   end

endmodule
